// ----- rtl/dre_pkg.sv -----
// Shared types and constants for the DNS response first-A-record extractor.
`default_nettype none

package dre_pkg;

  // Parse phases, one-hot
  typedef enum logic [12:0] {
    PH_HDR    = 13'b0_0000_0000_0001,
    PH_QNAME  = 13'b0_0000_0000_0010,
    PH_QLABEL = 13'b0_0000_0000_0100,
    PH_QPTR   = 13'b0_0000_0000_1000,
    PH_QFIXED = 13'b0_0000_0001_0000,
    PH_ANAME  = 13'b0_0000_0010_0000,
    PH_ALABEL = 13'b0_0000_0100_0000,
    PH_APTR   = 13'b0_0000_1000_0000,
    PH_AFIXED = 13'b0_0001_0000_0000,
    PH_ASKIP  = 13'b0_0010_0000_0000,
    PH_ARDATA = 13'b0_0100_0000_0000,
    PH_DONE   = 13'b0_1000_0000_0000,
    PH_FAIL   = 13'b1_0000_0000_0000
  } phase_t;

  localparam logic [15:0] QR_MASK      = 16'h8000;
  localparam logic [15:0] RCODE_MASK   = 16'h000F;
  localparam logic [15:0] TYPE_A       = 16'h0001;
  localparam logic [15:0] CLASS_IN     = 16'h0001;
  localparam logic [7:0]  PTR_MARK     = 8'hC0;
  localparam logic [7:0]  MAX_LABEL    = 8'd63;
  localparam logic [15:0] IPV4_RDLEN   = 16'd4;

  // Byte positions within the header and answer fixed part
  localparam logic [3:0] POS_ID       = 4'd1;
  localparam logic [3:0] POS_FLAGS    = 4'd3;
  localparam logic [3:0] POS_QDCOUNT  = 4'd5;
  localparam logic [3:0] POS_ANCOUNT  = 4'd7;
  localparam logic [3:0] POS_HDR_END  = 4'd11;
  localparam logic [3:0] POS_TYPE     = 4'd1;
  localparam logic [3:0] POS_CLASS    = 4'd3;
  localparam logic [3:0] POS_RDLEN    = 4'd9;
  localparam logic [3:0] POS_4TH      = 4'd3;

  // One finished message result
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] ip_address;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/dre_parser.sv -----
// Byte-wide DNS response parser: phase, counters and captured address.
`default_nettype none

module dre_parser
  import dre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] txn_id,
  output result_t          result
);

  phase_t      phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] answers_left, answers_left_next;
  logic [5:0]  label_left, label_left_next;
  logic [7:0]  held_high, held_high_next;
  logic        type_class_ok, type_class_ok_next;
  logic [15:0] rdata_length, rdata_length_next;
  logic [31:0] address_shift, address_shift_next;
  logic [15:0] word;

  assign word = {held_high, data_byte};

  // Work out the state after this byte
  always_comb begin
    phase_next          = phase;
    pos_next            = pos;
    questions_left_next = questions_left;
    answers_left_next   = answers_left;
    label_left_next     = label_left;
    held_high_next      = held_high;
    type_class_ok_next  = type_class_ok;
    rdata_length_next   = rdata_length;
    address_shift_next  = address_shift;
    unique case (phase)
      PH_HDR: begin
        pos_next = pos + 4'd1;
        priority if (!pos[0]) begin
          held_high_next = data_byte;
        end else if (pos == POS_ID) begin
          if (word != txn_id) phase_next = PH_FAIL;
        end else if (pos == POS_FLAGS) begin
          if ((word & QR_MASK) == 16'd0 || (word & RCODE_MASK) != 16'd0)
            phase_next = PH_FAIL;
        end else if (pos == POS_QDCOUNT) begin
          questions_left_next = word;
        end else if (pos == POS_ANCOUNT) begin
          answers_left_next = word;
        end else if (pos == POS_HDR_END) begin
          if (questions_left != 16'd0) phase_next = PH_QNAME;
          else phase_next = (answers_left != 16'd0) ? PH_ANAME : PH_FAIL;
        end else begin
          phase_next = phase;
        end
      end
      PH_QNAME, PH_ANAME: begin
        priority if (data_byte == 8'd0) begin
          phase_next = (phase == PH_ANAME) ? PH_AFIXED : PH_QFIXED;
          pos_next   = 4'd0;
        end else if ((data_byte & PTR_MARK) == PTR_MARK) begin
          phase_next = (phase == PH_ANAME) ? PH_APTR : PH_QPTR;
        end else if (data_byte > MAX_LABEL) begin
          phase_next = PH_FAIL;
        end else begin
          label_left_next = data_byte[5:0];
          phase_next      = (phase == PH_ANAME) ? PH_ALABEL : PH_QLABEL;
        end
      end
      PH_QLABEL, PH_ALABEL: begin
        label_left_next = label_left - 6'd1;
        if (label_left == 6'd1)
          phase_next = (phase == PH_ALABEL) ? PH_ANAME : PH_QNAME;
      end
      PH_QPTR: begin
        phase_next = PH_QFIXED;
        pos_next   = 4'd0;
      end
      PH_APTR: begin
        phase_next = PH_AFIXED;
        pos_next   = 4'd0;
      end
      PH_QFIXED: begin
        pos_next = pos + 4'd1;
        if (pos == POS_4TH) begin
          pos_next            = 4'd0;
          questions_left_next = questions_left - 16'd1;
          if (questions_left != 16'd1) phase_next = PH_QNAME;
          else phase_next = (answers_left != 16'd0) ? PH_ANAME : PH_FAIL;
        end
      end
      PH_AFIXED: begin
        pos_next = pos + 4'd1;
        priority if (!pos[0]) begin
          held_high_next = data_byte;
        end else if (pos == POS_TYPE) begin
          type_class_ok_next = (word == TYPE_A);
        end else if (pos == POS_CLASS) begin
          type_class_ok_next = type_class_ok && (word == CLASS_IN);
        end else if (pos == POS_RDLEN) begin
          rdata_length_next = word;
          pos_next          = 4'd0;
          priority if (type_class_ok && word == IPV4_RDLEN) begin
            address_shift_next = 32'd0;
            phase_next         = PH_ARDATA;
          end else if (word == 16'd0) begin
            answers_left_next = answers_left - 16'd1;
            phase_next = (answers_left != 16'd1) ? PH_ANAME : PH_FAIL;
          end else begin
            phase_next = PH_ASKIP;
          end
        end else begin
          phase_next = phase;
        end
      end
      PH_ASKIP: begin
        rdata_length_next = rdata_length - 16'd1;
        if (rdata_length == 16'd1) begin
          answers_left_next = answers_left - 16'd1;
          phase_next = (answers_left != 16'd1) ? PH_ANAME : PH_FAIL;
        end
      end
      PH_ARDATA: begin
        address_shift_next = {address_shift[23:0], data_byte};
        pos_next           = pos + 4'd1;
        if (pos == POS_4TH) phase_next = PH_DONE;
      end
      PH_DONE, PH_FAIL: begin
        phase_next = phase;
      end
      default: begin
        phase_next = PH_FAIL;
      end
    endcase
  end

  // Result for the final byte of a message
  always_comb begin
    result.valid      = accept && last_byte;
    result.found      = (phase_next == PH_DONE);
    result.ip_address = (phase_next == PH_DONE) ? address_shift_next : 32'd0;
  end

  // Advance on each word; restart after the final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase          <= PH_HDR;
      pos            <= 4'd0;
      questions_left <= 16'd0;
      answers_left   <= 16'd0;
      label_left     <= 6'd0;
      held_high      <= 8'd0;
      type_class_ok  <= 1'b0;
      rdata_length   <= 16'd0;
      address_shift  <= 32'd0;
    end else if (accept) begin
      phase          <= phase_next;
      pos            <= pos_next;
      questions_left <= questions_left_next;
      answers_left   <= answers_left_next;
      label_left     <= label_left_next;
      held_high      <= held_high_next;
      type_class_ok  <= type_class_ok_next;
      rdata_length   <= rdata_length_next;
      address_shift  <= address_shift_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dns_response_first_a_extractor.sv -----
// Top level: stream ports, id register and output buffer with skid stage.
`default_nettype none

// Takes a DNS response one byte per word on the slave side, tlast on the
// final byte, and gives one word on the master side per message: found in
// bit 0 and the first type-A, class-IN IPv4 address in bits 32:1 (zero when
// not found). Every byte is parsed in the cycle it is accepted, so one byte
// per clock is sustained while s_tready is high. A two-entry output buffer
// (result register plus skid) lets the next message stream in while a result
// waits; s_tready drops only while both entries are full. The expected
// transaction id is written through the always-ready cfg_valid/cfg_data;
// the user must do so only between messages, which the block does not check.
module dns_response_first_a_extractor
  import dre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,    // transaction id
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // data_byte
  input  wire logic        s_tlast,     // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata      // found, ip_address[32:1], zero pad
);

  logic [15:0] txn_id;
  logic        accept;
  result_t     res;
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_ip;
  logic        skid_valid;
  logic        skid_found;
  logic [31:0] skid_ip;
  logic        take;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign take      = out_valid && m_tready;

  // Hold the configured id
  always_ff @(posedge clk) begin
    if (rst) begin
      txn_id <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      txn_id <= cfg_data;
    end
  end

  dre_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .txn_id    (txn_id),
    .result    (res)
  );

  // Output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_found  <= skid_found;
          out_ip     <= skid_ip;
          skid_valid <= res.valid;
          skid_found <= res.found;
          skid_ip    <= res.ip_address;
        end else begin
          out_valid <= res.valid;
          out_found <= res.found;
          out_ip    <= res.ip_address;
        end
      end else if (res.valid) begin
        skid_valid <= 1'b1;
        skid_found <= res.found;
        skid_ip    <= res.ip_address;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_ip, out_found};

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("final byte accepted but no result presented");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == 32'd0))
    else $error("address nonzero on a not-found result");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_dns_response_first_a_extractor.sv -----
// Testbench for the DNS response first-A-record extractor: byte driver, result checker.
`timescale 1ns / 100ps

module tb_dns_response_first_a_extractor;
  import dre_pkg::*;

  localparam int          QFIXED_LEN     = 4;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES  = 8;
  localparam logic [15:0] FLAGS_OK       = 16'h8180;
  localparam logic [15:0] RR_CNAME       = 16'd5;
  localparam logic [15:0] RR_AAAA        = 16'd28;
  localparam logic [15:0] CLASS_CH       = 16'd3;
  localparam logic [7:0]  RESERVED_LO    = 8'd64;
  localparam logic [7:0]  RESERVED_HI    = 8'd191;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic        found;
    logic [31:0] ip;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // data_byte
  logic        s_tlast = 1'b0;  // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // found, ip_address, zero pad

  dns_response_first_a_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Stimulus and expectation stores
  stream_byte_t tx_bytes[$];
  lookup_t      lookups_due[$];
  logic [7:0]   msg[$];

  int fails = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_reqs = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic [15:0] cur_id = '0;

  // Parser copy kept by the checker
  phase_t      rx_phase;
  logic [15:0] id_want;
  logic [15:0] pos;
  logic [15:0] qd_left;
  logic [15:0] an_left;
  logic [5:0]  lbl_left;
  logic [7:0]  hi_byte;
  logic        rr_match;
  logic [15:0] rd_left;
  logic [31:0] addr_acc;
  logic        got_addr;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void clear_parse();
    rx_phase = PH_HDR;
    pos      = '0;
    qd_left  = '0;
    an_left  = '0;
    lbl_left = '0;
    hi_byte  = '0;
    rr_match = 1'b0;
    rd_left  = '0;
    addr_acc = '0;
    got_addr = 1'b0;
  endfunction

  function automatic void enter_answers();
    rx_phase = (an_left != 16'd0) ? PH_ANAME : PH_FAIL;
  endfunction

  function automatic void next_answer();
    an_left = an_left - 16'd1;
    enter_answers();
  endfunction

  // Length byte, terminator or pointer at the start of a name piece
  function automatic void take_name_byte(input logic [7:0] b, input logic ans);
    if (b == 8'h00) begin
      rx_phase = ans ? PH_AFIXED : PH_QFIXED;
      pos = '0;
    end else if ((b & PTR_MARK) == PTR_MARK) begin
      rx_phase = ans ? PH_APTR : PH_QPTR;
    end else if (b > MAX_LABEL) begin
      rx_phase = PH_FAIL;
    end else begin
      lbl_left = b[5:0];
      rx_phase = ans ? PH_ALABEL : PH_QLABEL;
    end
  endfunction

  function automatic void take_label_byte(input logic ans);
    lbl_left = lbl_left - 6'd1;
    if (lbl_left == 6'd0) rx_phase = ans ? PH_ANAME : PH_QNAME;
  endfunction

  // Advance the parser by one message byte
  function automatic void absorb_byte(input logic [7:0] b);
    logic [15:0] word;
    logic [15:0] at;
    word = {hi_byte, b};
    at = pos;
    case (rx_phase)
      PH_HDR: begin
        pos = at + 16'd1;
        if (!at[0]) begin
          hi_byte = b;
        end else if (at == POS_ID) begin
          if (word != id_want) rx_phase = PH_FAIL;
        end else if (at == POS_FLAGS) begin
          if ((word & QR_MASK) == 16'd0 || (word & RCODE_MASK) != 16'd0) rx_phase = PH_FAIL;
        end else if (at == POS_QDCOUNT) begin
          qd_left = word;
        end else if (at == POS_ANCOUNT) begin
          an_left = word;
        end else if (at == POS_HDR_END) begin
          if (qd_left != 16'd0) rx_phase = PH_QNAME;
          else enter_answers();
        end
      end
      PH_QNAME:  take_name_byte(b, 1'b0);
      PH_QLABEL: take_label_byte(1'b0);
      PH_QPTR: begin
        rx_phase = PH_QFIXED;
        pos = '0;
      end
      PH_QFIXED: begin
        pos = at + 16'd1;
        if (pos >= QFIXED_LEN) begin
          pos = '0;
          qd_left = qd_left - 16'd1;
          if (qd_left != 16'd0) rx_phase = PH_QNAME;
          else enter_answers();
        end
      end
      PH_ANAME:  take_name_byte(b, 1'b1);
      PH_ALABEL: take_label_byte(1'b1);
      PH_APTR: begin
        rx_phase = PH_AFIXED;
        pos = '0;
      end
      PH_AFIXED: begin
        pos = at + 16'd1;
        if (!at[0]) begin
          hi_byte = b;
        end else if (at == POS_TYPE) begin
          rr_match = (word == TYPE_A);
        end else if (at == POS_CLASS) begin
          rr_match = rr_match && (word == CLASS_IN);
        end else if (at == POS_RDLEN) begin
          rd_left = word;
          pos = '0;
          if (rr_match && word == IPV4_RDLEN) begin
            addr_acc = '0;
            rx_phase = PH_ARDATA;
          end else if (word == 16'd0) begin
            next_answer();
          end else begin
            rx_phase = PH_ASKIP;
          end
        end
      end
      PH_ASKIP: begin
        rd_left = rd_left - 16'd1;
        if (rd_left == 16'd0) next_answer();
      end
      PH_ARDATA: begin
        addr_acc = {addr_acc[23:0], b};
        pos = at + 16'd1;
        if (pos >= IPV4_RDLEN) begin
          got_addr = 1'b1;
          rx_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
    fails++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // ---------------------------------------------------------------- monitor

  // Track handshakes, predict on each accepted word, check each result word
  always @(posedge clk) begin : watch_ports
    lookup_t got;
    lookup_t want;
    if (rst) begin
      in_taken  <= 1'b0;
      cfg_taken <= 1'b0;
      id_want = '0;
      clear_parse();
    end else begin
      in_taken  <= s_tvalid && s_tready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) id_want = cfg_data;
      if (s_tvalid && s_tready) begin
        bytes_taken++;
        absorb_byte(s_tdata);
        if (s_tlast) begin
          want.found = got_addr;
          want.ip = got_addr ? addr_acc : 32'h0;
          lookups_due.push_back(want);
          clear_parse();
        end
      end
      if (m_tvalid && m_tready) begin
        got.found = m_tdata[0];
        got.ip = m_tdata[32:1];
        if (lookups_due.size() == 0) begin
          fails++;
          $error("result with nothing pending: found %0b ip_address %08h", got.found, got.ip);
        end else begin
          want = lookups_due.pop_front();
          if (got.found != want.found) flag_field("found", 32'(want.found), 32'(got.found));
          if (got.ip != want.ip) flag_field("ip_address", want.ip, got.ip);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver

  // Offer the next byte once the current word has gone, with random gaps
  always @(negedge clk) begin : drive_bytes
    stream_byte_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        w = tx_bytes.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= w.data;
        s_tlast  <= w.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : drive_ready
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen <= rx_hold_reqs;
      rx_hold_left <= RX_HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------- message building

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic void add16(input logic [15:0] v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endfunction

  function automatic void add_header(input logic [15:0] id, input logic [15:0] flags,
                                     input logic [15:0] qd, input logic [15:0] an);
    add16(id);
    add16(flags);
    add16(qd);
    add16(an);
    add16(16'($urandom));
    add16(16'($urandom));
  endfunction

  function automatic void add_labels(input int n, input int len);
    for (int k = 0; k < n; k++) begin
      msg.push_back(8'(len));
      repeat (len) msg.push_back(rand_byte());
    end
    msg.push_back(8'h00);
  endfunction

  function automatic void add_ptr();
    msg.push_back({2'b11, 6'($urandom)});
    msg.push_back(rand_byte());
  endfunction

  function automatic void add_qfixed();
    add16(TYPE_A);
    add16(CLASS_IN);
  endfunction

  // Fixed part of an answer and some rdata bytes; the name goes first
  function automatic void add_rr(input logic [15:0] rtype, input logic [15:0] rclass,
                                 input logic [15:0] rdlen, input int nbytes);
    add16(rtype);
    add16(rclass);
    add16(16'($urandom));
    add16(16'($urandom));
    add16(rdlen);
    repeat (nbytes) msg.push_back(rand_byte());
  endfunction

  function automatic void add_a(input logic [31:0] addr);
    add_rr(TYPE_A, CLASS_IN, IPV4_RDLEN, 0);
    for (int k = 3; k >= 0; k--) msg.push_back(addr[8*k +: 8]);
  endfunction

  // Random name: pointer, labels, labels plus pointer, root or a reserved length
  function automatic void add_name();
    int pick;
    int n;
    int len;
    pick = $urandom_range(99);
    if (pick < 4) begin
      msg.push_back(8'($urandom_range(RESERVED_LO, RESERVED_HI)));
    end else if (pick < 40) begin
      add_ptr();
    end else begin
      n = (pick < 45) ? 0 : $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        len = $urandom_range(1, 8);
        msg.push_back(8'(len));
        repeat (len) msg.push_back(rand_byte());
      end
      if (pick >= 85) add_ptr();
      else msg.push_back(8'h00);
    end
  endfunction

  // Move the built message to the driver queue, tlast on its final byte
  function automatic void send_msg();
    stream_byte_t w;
    for (int k = 0; k < msg.size(); k++) begin
      w.data = msg[k];
      w.last = (k == msg.size() - 1);
      tx_bytes.push_back(w);
    end
    bytes_queued += msg.size();
    msg.delete();
  endfunction

  function automatic void gen_random_msg();
    int pick;
    int qd;
    int an;
    int len;
    logic [15:0] id;
    logic [15:0] flags;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rdlen;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise: a few bytes of anything
      repeat ($urandom_range(1, 16)) msg.push_back(rand_byte());
    end else begin
      id = ($urandom_range(9) == 0) ? 16'($urandom) : cur_id;
      if ($urandom_range(9) != 0) flags = {1'b1, 11'($urandom), 4'h0};
      else if ($urandom_range(1) == 0) flags = {1'b0, 15'($urandom)};
      else flags = {1'b1, 11'($urandom), 4'($urandom_range(1, 15))};
      qd = $urandom_range(0, 2);
      an = $urandom_range(0, 3);
      add_header(id, flags,
                 ($urandom_range(9) == 0) ? 16'($urandom_range(0, 4)) : 16'(qd),
                 ($urandom_range(9) == 0) ? 16'($urandom_range(0, 4)) : 16'(an));
      repeat (qd) begin
        add_name();
        add16(16'($urandom));
        add16(16'($urandom));
      end
      repeat (an) begin
        add_name();
        pick = $urandom_range(99);
        rtype = (pick < 60) ? TYPE_A : (pick < 75) ? RR_CNAME : (pick < 85) ? RR_AAAA
                                                               : 16'($urandom);
        rclass = ($urandom_range(99) < 85) ? CLASS_IN : 16'($urandom);
        if (rtype == TYPE_A && rclass == CLASS_IN)
          rdlen = ($urandom_range(99) < 85) ? IPV4_RDLEN : 16'($urandom_range(0, 6));
        else
          rdlen = 16'($urandom_range(0, 8));
        add_rr(rtype, rclass, rdlen, int'(rdlen));
      end
      // cut short now and then, or pad with trailing bytes
      pick = $urandom_range(99);
      if (pick < 10 && msg.size() > 1) begin
        len = $urandom_range(1, msg.size() - 1);
        while (msg.size() > len) void'(msg.pop_back());
      end else if (pick < 20) begin
        repeat ($urandom_range(1, 4)) msg.push_back(rand_byte());
      end
    end
    send_msg();
  endfunction

  function automatic void directed_msgs();
    // plain hit, all-ones address
    add_header(cur_id, FLAGS_OK, 16'd1, 16'd1);
    add_labels(2, 3);
    add_qfixed();
    add_ptr();
    add_a(32'hFFFF_FFFF);
    send_msg();
    // no questions, all-zero address
    add_header(cur_id, FLAGS_OK, 16'd0, 16'd1);
    add_ptr();
    add_a(32'h0000_0000);
    send_msg();
    // wrong id, QR clear, nonzero rcode
    add_header(cur_id ^ 16'h0001, FLAGS_OK, 16'd1, 16'd1);
    add_labels(1, 4);
    add_qfixed();
    add_ptr();
    add_a(32'h0A00_0001);
    send_msg();
    add_header(cur_id, FLAGS_OK & ~QR_MASK, 16'd1, 16'd1);
    add_labels(1, 4);
    add_qfixed();
    add_ptr();
    add_a(32'h0A00_0002);
    send_msg();
    add_header(cur_id, FLAGS_OK | RCODE_MASK, 16'd0, 16'd1);
    add_ptr();
    add_a(32'h0A00_0003);
    send_msg();
    // no answers
    add_header(cur_id, FLAGS_OK, 16'd1, 16'd0);
    add_labels(1, 3);
    add_qfixed();
    send_msg();
    // alias record skipped, then a hit, then trailing bytes
    add_header(cur_id, FLAGS_OK, 16'd1, 16'd2);
    add_ptr();
    add_qfixed();
    add_ptr();
    add_rr(RR_CNAME, CLASS_IN, 16'd3, 3);
    add_ptr();
    add_a(32'h8000_0001);
    repeat (3) msg.push_back(rand_byte());
    send_msg();
    // wrong class and empty rdata exhaust the records
    add_header(cur_id, FLAGS_OK, 16'd0, 16'd2);
    add_ptr();
    add_rr(TYPE_A, CLASS_CH, IPV4_RDLEN, 4);
    add_ptr();
    add_rr(TYPE_A, CLASS_IN, 16'd0, 0);
    send_msg();
    // longest label, pointer question, label-named answer
    add_header(cur_id, FLAGS_OK, 16'd2, 16'd1);
    add_labels(1, 63);
    add_qfixed();
    add_ptr();
    add_qfixed();
    add_labels(2, 2);
    add_a(32'h0102_0304);
    send_msg();
    // reserved label lengths at both ends of the range
    add_header(cur_id, FLAGS_OK, 16'd1, 16'd1);
    msg.push_back(RESERVED_LO);
    repeat (6) msg.push_back(rand_byte());
    send_msg();
    add_header(cur_id, FLAGS_OK, 16'd1, 16'd1);
    msg.push_back(RESERVED_HI);
    repeat (6) msg.push_back(rand_byte());
    send_msg();
    // single-byte message, header one short, rdata cut short
    msg.push_back(8'h00);
    send_msg();
    add_header(cur_id, FLAGS_OK, 16'd0, 16'd1);
    void'(msg.pop_back());
    send_msg();
    add_header(cur_id, FLAGS_OK, 16'd0, 16'd1);
    add_ptr();
    add_rr(TYPE_A, CLASS_IN, IPV4_RDLEN, 2);
    send_msg();
    // huge counts and rdata length with the message ending early
    add_header(cur_id, FLAGS_OK, 16'hFFFF, 16'd1);
    add_labels(1, 5);
    add_qfixed();
    add_labels(1, 2);
    send_msg();
    add_header(cur_id, FLAGS_OK, 16'd0, 16'hFFFF);
    add_ptr();
    add_rr(RR_AAAA, CLASS_IN, 16'hFFFF, 20);
    send_msg();
  endfunction

  // ---------------------------------------------------------------- sequencing

  task automatic wait_drained();
    do @(negedge clk); while (bytes_taken != bytes_queued || lookups_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_txn_id(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    cur_id = v;
  endtask

  initial begin : stimulus
    int start;
    logic [15:0] id;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_txn_id(16'hFFFF);
    @(posedge clk);
    directed_msgs();

    // Random phases, each under its own id and one of four idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0:       id = 16'h0000;
        3:       id = 16'hFFFF;
        default: id = 16'($urandom);
      endcase
      write_txn_id(id);
      @(posedge clk);
      case (ph % 4)
        0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin src_idle_pct = 80; rx_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin src_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      // hold the result side off while bytes keep streaming in
      if (ph == 4) rx_hold_reqs++;
      start = bytes_queued;
      for (int n = 0; bytes_queued - start < 70 || n < 4; n++) gen_random_msg();
    end

    wait_drained();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
